[sv/pfr_pkg.sv]
// Package for the page frame replacement block.
// Holds field widths, request and result codes, defaults and the control structs.
// No dependencies.
package pfr_pkg;

    localparam int KIND_W   = 2;
    localparam int PAGE_W   = 31;
    localparam int STATUS_W = 3;
    localparam int FRAME_W  = 4;
    localparam int CFG_W    = 5;
    localparam int CFG_IDX_W = 2;

    localparam int DEF_FRAMES   = 16;
    localparam int DEF_PIN_BITS = 8;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_REF   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DIRTY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_UNPIN = 2'd2;
    localparam logic [KIND_W-1:0] KIND_FLUSH = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_HIT        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MISS_FREE  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EVICT      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ALL_PINNED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_RES    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DONE       = 3'd5;
    localparam logic [STATUS_W-1:0] ST_FLUSHED    = 3'd6;
    localparam logic [STATUS_W-1:0] ST_NONE       = 3'd7;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES = 2'd1;

    localparam logic [CFG_W-1:0] FRAMES_IN_USE_RST = 5'd16;

    typedef struct packed {
        logic load;        // capture the incoming request
        logic exec;        // apply a reference, mark or unpin and emit its result
        logic flush_emit;  // emit the next flush result
    } pfr_cmd_t;

    typedef struct packed {
        logic out_free;    // result register can take a result this cycle
        logic flush_last;  // the pending flush result is the final one
    } pfr_sts_t;

endpackage

[sv/pfr_if.sv]
// Request and result channel interfaces for the page frame replacement block.
// Depends on pfr_pkg.
interface pfr_req_if;
    import pfr_pkg::*;
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [PAGE_W-1:0]   page_number;
    logic                dirty_value;

    modport source (output valid, kind, page_number, dirty_value, input ready);
    modport sink   (input valid, kind, page_number, dirty_value, output ready);
endinterface

interface pfr_res_if;
    import pfr_pkg::*;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [FRAME_W-1:0]  frame;
    logic [PAGE_W-1:0]   other_page;
    logic                write_back;
    logic                last;

    modport source (output valid, status, frame, other_page, write_back, last,
                    input ready);
    modport sink   (input valid, status, frame, other_page, write_back, last,
                    output ready);
endinterface

[sv/page_frame_replacement_top.sv]
// Top level of the page frame replacement block (buffer pool frame manager).
// Depends on pfr_pkg, pfr_if, pfr_ctrl and pfr_datapath.
//
// Keeps up to FRAMES page frames with pin counts, dirty marks and a replacement
// order (FIFO or LRU, set by the policy register). Each request is one of:
// reference a page (hit pins it, miss fills a free frame or evicts the oldest
// unpinned frame), set a page's dirty mark, unpin a page, or flush. Requests are
// handled one at a time. A reference, mark or unpin goes through a page compare
// across all frames, a rank sort of the unpinned frames, the victim pick, then
// the table update, in which the result register also loads; ready returns with
// the result. Flush emits one result per cycle, while the result register is
// free, for each dirty unpinned frame, lowest frame first, with last set on the
// final result; a flush with nothing to write gives one "none" result. The result
// register lets a result wait for the consumer; the block stalls while it is
// full and the next result is ready. Configuration writes must be made only
// while no request is in flight; the block itself does not enforce this.
module page_frame_replacement_top
    import pfr_pkg::*;
#(
    parameter int FRAMES   = DEF_FRAMES,
    parameter int PIN_BITS = DEF_PIN_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    pfr_req_if.sink               req,
    pfr_res_if.source             res,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    pfr_cmd_t cmd;
    pfr_sts_t sts;

    // Sequence each request: compare, rank, pick, then update or flush walk.
    pfr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_flush (req.kind == KIND_FLUSH),
        .sts       (sts),
        .req_ready (req.ready),
        .cmd       (cmd)
    );

    // Hold the frame table and the result register.
    pfr_datapath #(
        .FRAMES   (FRAMES),
        .PIN_BITS (PIN_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_kind    (req.kind),
        .in_page    (req.page_number),
        .in_dval    (req.dirty_value),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .sts        (sts),
        .out_valid  (res.valid),
        .out_ready  (res.ready),
        .out_status (res.status),
        .out_frame  (res.frame),
        .out_page   (res.other_page),
        .out_wb     (res.write_back),
        .out_last   (res.last)
    );

endmodule

[sv/pfr_datapath.sv]
// Datapath: frame table, compare/rank/victim stages, update logic, result register.
// Depends on pfr_pkg; driven by pfr_ctrl through pfr_cmd_t.
module pfr_datapath #(
    parameter int FRAMES   = pfr_pkg::DEF_FRAMES,
    parameter int PIN_BITS = pfr_pkg::DEF_PIN_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [pfr_pkg::KIND_W-1:0]     in_kind,
    input  logic [pfr_pkg::PAGE_W-1:0]     in_page,
    input  logic                           in_dval,
    input  logic                           cfg_we,
    input  logic [pfr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pfr_pkg::CFG_W-1:0]      cfg_data,
    input  pfr_pkg::pfr_cmd_t              cmd,
    output pfr_pkg::pfr_sts_t              sts,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [pfr_pkg::STATUS_W-1:0]   out_status,
    output logic [pfr_pkg::FRAME_W-1:0]    out_frame,
    output logic [pfr_pkg::PAGE_W-1:0]     out_page,
    output logic                           out_wb,
    output logic                           out_last
);
    import pfr_pkg::*;

    localparam int IW = $clog2(FRAMES);
    localparam int CW = $clog2(FRAMES + 1);
    localparam int LW = (CW > CFG_W) ? CW : CFG_W;
    localparam logic [PIN_BITS-1:0] PIN_MAX = '1;

    // configuration
    logic             policy_reg;
    logic [CFG_W-1:0] fiu_reg;

    // captured request
    logic [KIND_W-1:0] kind_reg;
    logic [PAGE_W-1:0] pg_reg;
    logic              dval_reg;

    // frame table
    logic [FRAMES-1:0]   valid_reg, valid_next;
    logic [FRAMES-1:0]   dirty_reg, dirty_next;
    logic [PIN_BITS-1:0] pin_reg  [FRAMES];
    logic [PIN_BITS-1:0] pin_next [FRAMES];
    logic [IW-1:0]       rank_reg [FRAMES];
    logic [IW-1:0]       rank_next[FRAMES];
    logic [CW-1:0]       filled_reg, filled_next;
    logic [PAGE_W-1:0]   page_mem [FRAMES];

    // lookup stages
    logic [FRAMES-1:0] hit_vec_reg;
    logic [FRAMES-1:0] cand_reg;
    logic [FRAMES-1:0] rank_vec_reg;
    logic [IW-1:0]     hit_idx_reg;
    logic [IW-1:0]     victim_idx_reg;
    logic              victim_ok_reg;

    // result register
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [FRAME_W-1:0]  out_frame_reg;
    logic [PAGE_W-1:0]   out_page_reg;
    logic                out_wb_reg;
    logic                out_last_reg;

    function automatic logic [IW-1:0] low_index(input logic [FRAMES-1:0] v);
        logic [IW-1:0] idx;
        idx = '0;
        for (int i = FRAMES - 1; i >= 0; i--)
        begin
            if (v[i])
                idx = IW'(i);
        end
        return idx;
    endfunction

    function automatic logic [IW-1:0] high_index(input logic [FRAMES-1:0] v);
        logic [IW-1:0] idx;
        idx = '0;
        for (int i = 0; i < FRAMES; i++)
        begin
            if (v[i])
                idx = IW'(i);
        end
        return idx;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= 1'b0;
            fiu_reg    <= FRAMES_IN_USE_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_POLICY)
                policy_reg <= cfg_data[0];
            else if (cfg_index == CFG_FRAMES)
                fiu_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= in_kind;
            pg_reg   <= in_page;
            dval_reg <= in_dval;
        end
    end

    // Compare, rank and victim stages; they recompute every cycle from the held request.
    logic [IW-1:0]     top_rank;
    logic [FRAMES-1:0] victim_vec;
    logic [FRAMES-1:0] hit_vec_d;
    logic [FRAMES-1:0] cand_d;
    logic [FRAMES-1:0] rank_vec_d;

    always_comb
    begin
        for (int i = 0; i < FRAMES; i++)
        begin
            hit_vec_d[i] = valid_reg[i] && (page_mem[i] == pg_reg);
            cand_d[i]    = valid_reg[i] && (pin_reg[i] == '0);
        end
        for (int r = 0; r < FRAMES; r++)
        begin
            rank_vec_d[r] = 1'b0;
            for (int i = 0; i < FRAMES; i++)
            begin
                if (cand_reg[i] && (rank_reg[i] == IW'(r)))
                    rank_vec_d[r] = 1'b1;
            end
        end
        top_rank = high_index(rank_vec_reg);
        for (int i = 0; i < FRAMES; i++)
            victim_vec[i] = cand_reg[i] && (rank_reg[i] == top_rank);
    end

    always_ff @(posedge clk)
    begin
        hit_vec_reg    <= hit_vec_d;
        cand_reg       <= cand_d;
        rank_vec_reg   <= rank_vec_d;
        hit_idx_reg    <= low_index(hit_vec_reg);
        victim_idx_reg <= low_index(victim_vec);
        victim_ok_reg  <= |rank_vec_reg;
    end

    // limit and flush selection
    logic [LW-1:0]     fiu_ext, lim;
    logic              free_ok;
    logic [FRAMES-1:0] fmask, fbit;
    logic [IW-1:0]     fidx;

    always_comb
    begin
        fiu_ext = LW'(fiu_reg);
        if (fiu_ext == '0)
            lim = LW'(1);
        else if (fiu_ext > LW'(FRAMES))
            lim = LW'(FRAMES);
        else
            lim = fiu_ext;
        free_ok = LW'(filled_reg) < lim;
        for (int i = 0; i < FRAMES; i++)
            fmask[i] = valid_reg[i] && dirty_reg[i] && (pin_reg[i] == '0);
        fbit = fmask & (~fmask + FRAMES'(1));
        fidx = low_index(fbit);
    end

    // update and result selection
    logic                hit;
    logic                tf_en;
    logic [IW-1:0]       tf_idx;
    logic                fill_en;
    logic [IW-1:0]       fill_idx;
    logic                pwr;
    logic [IW-1:0]       pwr_idx;
    logic                emit;
    logic [STATUS_W-1:0] e_status;
    logic [IW-1:0]       e_frame;
    logic [PAGE_W-1:0]   e_page;
    logic                e_wb;
    logic                e_last;

    always_comb
    begin
        valid_next  = valid_reg;
        dirty_next  = dirty_reg;
        filled_next = filled_reg;
        pin_next    = pin_reg;
        hit         = |hit_vec_reg;
        tf_en       = 1'b0;
        tf_idx      = hit_idx_reg;
        fill_en     = 1'b0;
        fill_idx    = filled_reg[IW-1:0];
        pwr         = 1'b0;
        pwr_idx     = fill_idx;
        emit        = 1'b0;
        e_status    = ST_NONE;
        e_frame     = '0;
        e_page      = '0;
        e_wb        = 1'b0;
        e_last      = 1'b1;

        if (cmd.exec)
        begin
            emit = 1'b1;
            if (kind_reg == KIND_REF)
            begin
                if (hit)
                begin
                    if (pin_reg[hit_idx_reg] != PIN_MAX)
                        pin_next[hit_idx_reg] = pin_reg[hit_idx_reg] + PIN_BITS'(1);
                    tf_en    = policy_reg;
                    e_status = ST_HIT;
                    e_frame  = hit_idx_reg;
                end
                else if (free_ok)
                begin
                    fill_en              = 1'b1;
                    pwr                  = 1'b1;
                    valid_next[fill_idx] = 1'b1;
                    dirty_next[fill_idx] = 1'b0;
                    pin_next[fill_idx]   = PIN_BITS'(1);
                    filled_next          = filled_reg + CW'(1);
                    e_status             = ST_MISS_FREE;
                    e_frame              = fill_idx;
                end
                else if (victim_ok_reg)
                begin
                    tf_en                      = 1'b1;
                    tf_idx                     = victim_idx_reg;
                    pwr                        = 1'b1;
                    pwr_idx                    = victim_idx_reg;
                    dirty_next[victim_idx_reg] = 1'b0;
                    pin_next[victim_idx_reg]   = PIN_BITS'(1);
                    e_status                   = ST_EVICT;
                    e_frame                    = victim_idx_reg;
                    e_page                     = page_mem[victim_idx_reg];
                    e_wb                       = dirty_reg[victim_idx_reg];
                end
                else
                begin
                    e_status = ST_ALL_PINNED;
                end
            end
            else if (!hit)
            begin
                e_status = ST_NOT_RES;
            end
            else
            begin
                if (kind_reg == KIND_DIRTY)
                    dirty_next[hit_idx_reg] = dval_reg;
                else if (pin_reg[hit_idx_reg] != '0)
                    pin_next[hit_idx_reg] = pin_reg[hit_idx_reg] - PIN_BITS'(1);
                e_status = ST_DONE;
                e_frame  = hit_idx_reg;
            end
        end
        else if (cmd.flush_emit)
        begin
            emit = 1'b1;
            if (|fmask)
            begin
                dirty_next[fidx] = 1'b0;
                e_status         = ST_FLUSHED;
                e_frame          = fidx;
                e_page           = page_mem[fidx];
                e_wb             = 1'b1;
                e_last           = (fmask & ~fbit) == '0;
            end
        end

        // ranks: move a frame to the front, or age everything for a fill
        for (int i = 0; i < FRAMES; i++)
        begin
            rank_next[i] = rank_reg[i];
            if (tf_en && valid_reg[i] && (IW'(i) != tf_idx) && (rank_reg[i] < rank_reg[tf_idx]))
                rank_next[i] = rank_reg[i] + IW'(1);
            if (fill_en && valid_reg[i])
                rank_next[i] = rank_reg[i] + IW'(1);
        end
        if (tf_en)
            rank_next[tf_idx] = '0;
        if (fill_en)
            rank_next[fill_idx] = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            dirty_reg  <= '0;
            filled_reg <= '0;
            for (int i = 0; i < FRAMES; i++)
            begin
                pin_reg[i]  <= '0;
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg  <= valid_next;
            dirty_reg  <= dirty_next;
            filled_reg <= filled_next;
            pin_reg    <= pin_next;
            rank_reg   <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pwr)
            page_mem[pwr_idx] <= pg_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_status_reg <= e_status;
            out_frame_reg  <= FRAME_W'(e_frame);
            out_page_reg   <= e_page;
            out_wb_reg     <= e_wb;
            out_last_reg   <= e_last;
        end
    end

    assign sts.out_free   = !out_valid_reg || out_ready;
    assign sts.flush_last = (fmask & ~fbit) == '0;

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_frame  = out_frame_reg;
    assign out_page   = out_page_reg;
    assign out_wb     = out_wb_reg;
    assign out_last   = out_last_reg;

endmodule

[sv/pfr_ctrl.sv]
// Controller state machine: sequences lookup, execute and flush for one request.
// Depends on pfr_pkg; commands pfr_datapath.
module pfr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_flush,
    input  pfr_pkg::pfr_sts_t sts,
    output logic              req_ready,
    output pfr_pkg::pfr_cmd_t cmd
);
    import pfr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_RANK,
        S_PICK,
        S_EXEC,
        S_FLUSH
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid && ready_reg)
                begin
                    cmd.load   = 1'b1;
                    state_next = req_flush ? S_FLUSH : S_LOOK;
                end
            end
            S_LOOK:  state_next = S_RANK;
            S_RANK:  state_next = S_PICK;
            S_PICK:  state_next = S_EXEC;
            S_EXEC:
            begin
                if (sts.out_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_FLUSH:
            begin
                if (sts.out_free)
                begin
                    cmd.flush_emit = 1'b1;
                    if (sts.flush_last)
                        state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= (state_next == S_IDLE);
        end
    end

    assign req_ready = ready_reg;

endmodule

[sv/pfr_checker.sv]
// Port-level checks for page_frame_replacement_top, bound to the top level.
// Depends on pfr_pkg.
module pfr_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          res_valid,
    input logic                          res_ready,
    input logic [pfr_pkg::STATUS_W-1:0]  res_status,
    input logic [pfr_pkg::FRAME_W-1:0]   res_frame,
    input logic [pfr_pkg::PAGE_W-1:0]    res_other_page,
    input logic                          res_write_back,
    input logic                          res_last
);
    import pfr_pkg::*;

    // hold a stalled result
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_status) && $stable(res_frame))
        else $error("result changed while stalled");

    // one request at a time
    a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while another in flight");

    // only flush can give more than one result
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_status != ST_FLUSHED |-> res_last)
        else $error("non-flush result without last");

    // an empty flush carries no page
    a_none: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_status == ST_NONE |->
            res_frame == '0 && res_other_page == '0 && !res_write_back)
        else $error("empty flush result carries data");

    // write back only on eviction or flush
    a_wb: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_write_back |->
            res_status == ST_EVICT || res_status == ST_FLUSHED)
        else $error("write back on wrong status");

endmodule

bind page_frame_replacement_top pfr_checker u_pfr_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .res_valid      (res.valid),
    .res_ready      (res.ready),
    .res_status     (res.status),
    .res_frame      (res.frame),
    .res_other_page (res.other_page),
    .res_write_back (res.write_back),
    .res_last       (res.last)
);

[tb/sv/pfr_pool_checker.sv]
`timescale 1ns / 1ps
// Result checker for the page frame replacement block: it predicts the pool and
// compares every result. Depends on pfr_pkg and pfr_if.
module pfr_pool_checker
    import pfr_pkg::*;
#(
    parameter int FRAMES   = DEF_FRAMES,
    parameter int PIN_BITS = DEF_PIN_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    pfr_req_if                   req,
    pfr_res_if                   res,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   mismatches,
    output int                   outstanding
);

    localparam int PIN_MAX = (1 << PIN_BITS) - 1;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FRAME_W-1:0]  frame;
        logic [PAGE_W-1:0]   other_page;
        logic                write_back;
        logic                last;
    } pool_result_t;

    pool_result_t awaited[$];

    logic              lru_mode;
    logic [CFG_W-1:0]  fill_limit;
    logic              held[FRAMES];
    logic [PAGE_W-1:0] held_page[FRAMES];
    int                pins[FRAMES];
    logic              dirty[FRAMES];
    int                rank[FRAMES];
    int                filled;

    task automatic report(string field, int unsigned seen, int unsigned want);
        $display("MISMATCH at %0t: %s got %0h, wanted %0h", $realtime, field, seen, want);
        mismatches++;
    endtask

    task automatic push(logic [STATUS_W-1:0] st, int f, logic [PAGE_W-1:0] pg,
                        logic wb, logic lst);
        pool_result_t r;
        r.status = st;
        r.frame = f[FRAME_W-1:0];
        r.other_page = pg;
        r.write_back = wb;
        r.last = lst;
        awaited.push_back(r);
    endtask

    function automatic int lookup(logic [PAGE_W-1:0] pg);
        for (int i = 0; i < FRAMES; i++)
            if (held[i] && held_page[i] == pg)
                return i;
        return -1;
    endfunction

    // Age every frame newer than the old rank, then bring f to the front.
    task automatic bring_front(int f);
        int old;
        old = rank[f];
        for (int i = 0; i < FRAMES; i++)
            if (held[i] && i != f && rank[i] < old)
                rank[i]++;
        rank[f] = 0;
    endtask

    task automatic predict(logic [KIND_W-1:0] kind, logic [PAGE_W-1:0] pg, logic dval);
        int f;
        int lim;
        int n;
        if (kind == KIND_REF) begin
            f = lookup(pg);
            lim = (fill_limit < 1) ? 1 : (fill_limit > FRAMES) ? FRAMES : int'(fill_limit);
            if (f >= 0) begin
                if (pins[f] < PIN_MAX)
                    pins[f]++;
                if (lru_mode)
                    bring_front(f);
                push(ST_HIT, f, '0, 1'b0, 1'b1);
            end
            else if (filled < lim && filled < FRAMES) begin
                f = filled;
                for (int i = 0; i < FRAMES; i++)
                    if (held[i])
                        rank[i]++;
                held[f] = 1'b1;
                held_page[f] = pg;
                pins[f] = 1;
                dirty[f] = 1'b0;
                rank[f] = 0;
                filled++;
                push(ST_MISS_FREE, f, '0, 1'b0, 1'b1);
            end
            else begin
                f = -1;
                for (int i = 0; i < FRAMES; i++)
                    if (held[i] && pins[i] == 0 && (f < 0 || rank[i] > rank[f]))
                        f = i;
                if (f < 0)
                    push(ST_ALL_PINNED, 0, '0, 1'b0, 1'b1);
                else begin
                    push(ST_EVICT, f, held_page[f], dirty[f], 1'b1);
                    bring_front(f);
                    held_page[f] = pg;
                    pins[f] = 1;
                    dirty[f] = 1'b0;
                end
            end
        end
        else if (kind == KIND_DIRTY || kind == KIND_UNPIN) begin
            f = lookup(pg);
            if (f < 0)
                push(ST_NOT_RES, 0, '0, 1'b0, 1'b1);
            else begin
                if (kind == KIND_DIRTY)
                    dirty[f] = dval;
                else if (pins[f] > 0)
                    pins[f]--;
                push(ST_DONE, f, '0, 1'b0, 1'b1);
            end
        end
        else begin
            n = 0;
            for (int i = 0; i < FRAMES; i++)
                if (held[i] && dirty[i] && pins[i] == 0) begin
                    dirty[i] = 1'b0;
                    push(ST_FLUSHED, i, held_page[i], 1'b1, 1'b0);
                    n++;
                end
            if (n == 0)
                push(ST_NONE, 0, '0, 1'b0, 1'b1);
            else
                awaited[$].last = 1'b1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pool_result_t want;
        if (!rst_n) begin
            lru_mode = 1'b0;
            fill_limit = FRAMES_IN_USE_RST;
            filled = 0;
            for (int i = 0; i < FRAMES; i++) begin
                held[i] = 1'b0;
                held_page[i] = '0;
                pins[i] = 0;
                dirty[i] = 1'b0;
                rank[i] = 0;
            end
        end
        else begin
            if (cfg_we) begin
                if (cfg_index == CFG_POLICY)
                    lru_mode = cfg_data[0];
                else if (cfg_index == CFG_FRAMES)
                    fill_limit = cfg_data;
            end
            // Results of this edge belong to earlier requests, so check them first.
            if (res.valid && res.ready) begin
                if (awaited.size() == 0)
                    report("unrequested result, status", res.status, 0);
                else begin
                    want = awaited.pop_front();
                    if (res.status !== want.status)
                        report("status", res.status, want.status);
                    if (res.frame !== want.frame)
                        report("frame", res.frame, want.frame);
                    if (res.other_page !== want.other_page)
                        report("other_page", res.other_page, want.other_page);
                    if (res.write_back !== want.write_back)
                        report("write_back", res.write_back, want.write_back);
                    if (res.last !== want.last)
                        report("last", res.last, want.last);
                end
            end
            if (req.valid && req.ready)
                predict(req.kind, req.page_number, req.dirty_value);
        end
        outstanding = awaited.size();
    end

    initial
    begin
        mismatches = 0;
        outstanding = 0;
    end

endmodule

[tb/sv/page_frame_replacement_top_test.sv]
`timescale 1ns / 1ps
// Stimulus and verdict for the page frame replacement block.
// Depends on pfr_pkg, pfr_if, page_frame_replacement_top and pfr_pool_checker.
module page_frame_replacement_top_test;
    import pfr_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    int                   mismatches;
    int                   outstanding;
    int                   cycles;
    bit                   calm;     // last part of the run: no idling anywhere

    logic [PAGE_W-1:0]    page_pool[24];

    pfr_req_if req ();
    pfr_res_if res ();

    page_frame_replacement_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pfr_pool_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .res         (res),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Stop a hung run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Result side: stall in random bursts, hold ready high once calm.
    initial
    begin
        res.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (calm || $urandom_range(0, 2) != 0) begin
                res.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
            else begin
                res.ready <= 1'b0;
                repeat ($urandom_range(0, 13)) @(posedge clk);
            end
        end
    end

    // Hold valid with the request until it is taken; leave valid high afterwards
    // so back-to-back requests need no second assignment in one step.
    task automatic send(logic [KIND_W-1:0] kind, logic [PAGE_W-1:0] pg, logic dval);
        req.valid <= 1'b1;
        req.kind <= kind;
        req.page_number <= pg;
        req.dirty_value <= dval;
        do
            @(posedge clk);
        while (!req.ready);
    endtask

    // Drop valid for a random burst, now and then.
    task automatic maybe_gap();
        if (!calm && $urandom_range(0, 3) == 0) begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    // Drain every awaited result, then let a trailing flush settle.
    task automatic drain();
        req.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Write both registers while the block is idle.
    task automatic configure(logic lru, logic [CFG_W-1:0] limit);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= CFG_POLICY;
        cfg_data <= {{(CFG_W-1){1'b0}}, lru};
        @(posedge clk);
        cfg_index <= CFG_FRAMES;
        cfg_data <= limit;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [PAGE_W-1:0] pick_page(int span);
        logic [31:0] r;
        r = $urandom;
        if ($urandom_range(0, 9) == 0)
            return r[PAGE_W-1:0];
        return page_pool[$urandom_range(0, span - 1)];
    endfunction

    // Mostly references and unpins over a pool slightly larger than the frame
    // limit, so hits, fills, evictions and refusals all happen.
    task automatic random_requests(int count, int span);
        int pick;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                send(KIND_REF, pick_page(span), 1'($urandom));
            else if (pick < 65)
                send(KIND_DIRTY, pick_page(span), 1'($urandom));
            else if (pick < 90)
                send(KIND_UNPIN, pick_page(span), 1'($urandom));
            else
                send(KIND_FLUSH, 31'($urandom), 1'($urandom));
            maybe_gap();
        end
    endtask

    initial
    begin
        logic [PAGE_W-1:0] pa;
        logic [PAGE_W-1:0] pb;
        logic [PAGE_W-1:0] pc;
        rst_n = 1'b0;
        calm = 1'b0;
        cycles = 0;
        cfg_we = 1'b0;
        cfg_index = CFG_POLICY;
        cfg_data = '0;
        req.valid = 1'b0;
        req.kind = KIND_REF;
        req.page_number = '0;
        req.dirty_value = 1'b0;
        page_pool[0] = '0;
        page_pool[1] = {PAGE_W{1'b1}};
        for (int i = 2; i < 24; i++)
            page_pool[i] = 31'($urandom);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: two frames, FIFO.
        pa = page_pool[1];
        pb = page_pool[0];
        pc = page_pool[2];
        configure(1'b0, 5'd2);
        send(KIND_FLUSH, '0, 1'b0);          // empty pool: nothing to flush
        send(KIND_DIRTY, pa, 1'b1);          // not resident
        send(KIND_UNPIN, pa, 1'b0);          // not resident
        send(KIND_REF, pa, 1'b0);            // free frame 0
        send(KIND_REF, pb, 1'b0);            // free frame 1
        send(KIND_REF, pa, 1'b0);            // hit, pin 2
        send(KIND_REF, pc, 1'b0);            // every frame pinned: refused
        send(KIND_UNPIN, pb, 1'b0);
        send(KIND_UNPIN, pb, 1'b0);          // pin stays at zero
        send(KIND_DIRTY, pb, 1'b1);
        send(KIND_DIRTY, pa, 1'b1);
        send(KIND_FLUSH, '0, 1'b0);          // only the unpinned dirty page goes
        send(KIND_DIRTY, pb, 1'b1);
        send(KIND_REF, pc, 1'b0);            // evicts pb with write-back
        send(KIND_UNPIN, pa, 1'b0);
        send(KIND_UNPIN, pa, 1'b0);
        send(KIND_UNPIN, pc, 1'b0);
        send(KIND_DIRTY, pc, 1'b1);
        send(KIND_FLUSH, '0, 1'b0);          // two results, last on the second
        send(KIND_DIRTY, pa, 1'b0);          // clear a mark
        send(KIND_REF, pb, 1'b0);            // evicts the oldest clean page
        send(KIND_FLUSH, '0, 1'b0);

        // Pin saturation: one frame limit, LRU; a miss then 256 hits pin the
        // page at the ceiling, so a few unpins leave it pinned.
        configure(1'b1, 5'd1);
        for (int k = 0; k < 257; k++)
            send(KIND_REF, pa, 1'b0);
        send(KIND_DIRTY, pa, 1'b1);
        for (int k = 0; k < 3; k++)
            send(KIND_UNPIN, pa, 1'b0);
        send(KIND_FLUSH, '0, 1'b0);          // dirty but pinned: nothing to flush
        send(KIND_REF, pc, 1'b0);

        // Random phases across several settings, extremes included.
        configure(1'b0, 5'd16);
        random_requests(15, 20);
        configure(1'b1, 5'd16);
        random_requests(15, 20);
        configure(1'b1, 5'd4);
        random_requests(15, 7);
        drain();                             // pause until the pool is quiet
        random_requests(5, 7);
        configure(1'b0, 5'd0);
        random_requests(10, 3);
        configure(1'b1, 5'd31);
        random_requests(15, 24);
        configure(1'b0, 5'd3);
        random_requests(15, 6);
        configure(1'b1, 5'd17);
        random_requests(15, 24);
        configure(1'b1, 5'($urandom_range(1, 15)));
        calm = 1'b1;
        random_requests(20, 12);

        req.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
